/* design/gn3_pkg.sv */
// Package: permutation ROM, gradient decode and shared types for the gradient noise block.
`timescale 1ns / 1ps
package gn3_pkg;

   localparam int FracBitsDefault = 16;
   localparam int CellBits = 8;
   localparam int CoordBits = 32;
   localparam int NoiseBits = 16;

   localparam logic [7:0] HashRom [256] = '{
      8'd182, 8'd232, 8'd51, 8'd15, 8'd55, 8'd119, 8'd7, 8'd107,
      8'd230, 8'd227, 8'd6, 8'd34, 8'd216, 8'd61, 8'd183, 8'd36,
      8'd40, 8'd134, 8'd74, 8'd45, 8'd157, 8'd78, 8'd81, 8'd114,
      8'd145, 8'd9, 8'd209, 8'd189, 8'd147, 8'd58, 8'd126, 8'd0,
      8'd240, 8'd169, 8'd228, 8'd235, 8'd67, 8'd198, 8'd72, 8'd64,
      8'd88, 8'd98, 8'd129, 8'd194, 8'd99, 8'd71, 8'd30, 8'd127,
      8'd18, 8'd150, 8'd155, 8'd179, 8'd132, 8'd62, 8'd116, 8'd200,
      8'd251, 8'd178, 8'd32, 8'd140, 8'd130, 8'd139, 8'd250, 8'd26,
      8'd151, 8'd203, 8'd106, 8'd123, 8'd53, 8'd255, 8'd75, 8'd254,
      8'd86, 8'd234, 8'd223, 8'd19, 8'd199, 8'd244, 8'd241, 8'd1,
      8'd172, 8'd70, 8'd24, 8'd97, 8'd196, 8'd10, 8'd90, 8'd246,
      8'd252, 8'd68, 8'd84, 8'd161, 8'd236, 8'd205, 8'd80, 8'd91,
      8'd233, 8'd225, 8'd164, 8'd217, 8'd239, 8'd220, 8'd20, 8'd46,
      8'd204, 8'd35, 8'd31, 8'd175, 8'd154, 8'd17, 8'd133, 8'd117,
      8'd73, 8'd224, 8'd125, 8'd65, 8'd77, 8'd173, 8'd3, 8'd2,
      8'd242, 8'd221, 8'd120, 8'd218, 8'd56, 8'd190, 8'd166, 8'd11,
      8'd138, 8'd208, 8'd231, 8'd50, 8'd135, 8'd109, 8'd213, 8'd187,
      8'd152, 8'd201, 8'd47, 8'd168, 8'd185, 8'd186, 8'd167, 8'd165,
      8'd102, 8'd153, 8'd156, 8'd49, 8'd202, 8'd69, 8'd195, 8'd92,
      8'd21, 8'd229, 8'd63, 8'd104, 8'd197, 8'd136, 8'd148, 8'd94,
      8'd171, 8'd93, 8'd59, 8'd149, 8'd23, 8'd144, 8'd160, 8'd57,
      8'd76, 8'd141, 8'd96, 8'd158, 8'd163, 8'd219, 8'd237, 8'd113,
      8'd206, 8'd181, 8'd112, 8'd111, 8'd191, 8'd137, 8'd207, 8'd215,
      8'd13, 8'd83, 8'd238, 8'd249, 8'd100, 8'd131, 8'd118, 8'd243,
      8'd162, 8'd248, 8'd43, 8'd66, 8'd226, 8'd27, 8'd211, 8'd95,
      8'd214, 8'd105, 8'd108, 8'd101, 8'd170, 8'd128, 8'd210, 8'd87,
      8'd38, 8'd44, 8'd174, 8'd188, 8'd176, 8'd39, 8'd14, 8'd143,
      8'd159, 8'd16, 8'd124, 8'd222, 8'd33, 8'd247, 8'd37, 8'd245,
      8'd8, 8'd4, 8'd22, 8'd82, 8'd110, 8'd180, 8'd184, 8'd12,
      8'd25, 8'd5, 8'd193, 8'd41, 8'd85, 8'd177, 8'd192, 8'd253,
      8'd79, 8'd29, 8'd115, 8'd103, 8'd142, 8'd146, 8'd52, 8'd48,
      8'd89, 8'd54, 8'd121, 8'd212, 8'd122, 8'd60, 8'd28, 8'd42
   };

   // hash mod 12 by repeated conditional subtraction
   function automatic logic [3:0] mod12(input logic [7:0] h);
      logic [8:0] t;
      t = {1'b0, h};
      for (int i = 0; i < 5; i++) begin
         if (t >= 9'd192 >> i) t = t - (9'd192 >> i);
      end
      if (t >= 9'd12) t = t - 9'd12;
      return t[3:0];
   endfunction

   // gradient components: 2-bit code, 00 zero, 01 plus, 11 minus
   typedef struct packed {
      logic [1:0] gx;
      logic [1:0] gy;
      logic [1:0] gz;
   } grad_type;

   localparam logic [1:0] GPos = 2'b01;
   localparam logic [1:0] GNeg = 2'b11;
   localparam logic [1:0] GZero = 2'b00;

   function automatic grad_type grad_of(input logic [3:0] g);
      grad_type r;
      r = '{GZero, GZero, GZero};
      case (g)
         4'd0: r = '{GPos, GPos, GZero};
         4'd1: r = '{GNeg, GPos, GZero};
         4'd2: r = '{GPos, GNeg, GZero};
         4'd3: r = '{GNeg, GNeg, GZero};
         4'd4: r = '{GPos, GZero, GPos};
         4'd5: r = '{GNeg, GZero, GPos};
         4'd6: r = '{GPos, GZero, GNeg};
         4'd7: r = '{GNeg, GZero, GNeg};
         4'd8: r = '{GZero, GPos, GPos};
         4'd9: r = '{GZero, GNeg, GPos};
         4'd10: r = '{GZero, GPos, GNeg};
         4'd11: r = '{GZero, GNeg, GNeg};
         default: r = '{GZero, GZero, GZero};
      endcase
      return r;
   endfunction

endpackage

/* design/gn3_fade.sv */
// Quintic fade of one fraction, three register stages.
`timescale 1ns / 1ps
module gn3_fade #(
   parameter int FRAC_BITS = gn3_pkg::FracBitsDefault
) (
   input  logic                 clock,
   input  logic [FRAC_BITS-1:0] frac,
   output logic [FRAC_BITS:0]   fade
);
   localparam int FB = FRAC_BITS;
   // p = 6s - 15f + 10T lies in (0, 10T]
   localparam int PB = FB + 4;

   logic [FB-1:0] f1_ff, f1_in;
   logic [FB-1:0] s_ff, s_in;
   logic [FB-1:0] c_ff, c_in;
   logic [PB-1:0] p_ff, p_in;
   logic [2*FB-1:0] sq;
   logic [2*FB-1:0] cu;
   logic [PB+FB-1:0] pr;
   logic [FB:0] fade_ff, fade_in;

   // stage 1: square
   assign sq = frac * frac;
   assign s_in = sq[2*FB-1:FB];
   assign f1_in = frac;

   // stage 2: cube and polynomial
   assign cu = s_ff * f1_ff;
   assign c_in = cu[2*FB-1:FB];
   assign p_in = PB'(6 * {4'b0, s_ff}) - PB'(15 * {4'b0, f1_ff})
               + PB'(10 * (PB'(1) << FB));

   // stage 3: product
   assign pr = (PB+FB)'(c_ff) * (PB+FB)'(p_ff);
   assign fade_in = pr[2*FB:FB];
   assign fade = fade_ff;

   always_ff @(posedge clock) begin
      f1_ff <= f1_in;
      s_ff <= s_in;
      c_ff <= c_in;
      p_ff <= p_in;
      fade_ff <= fade_in;
   end
endmodule

/* design/gn3_corner.sv */
// Corner hashing and gradient dot products, four register stages.
`timescale 1ns / 1ps
module gn3_corner #(
   parameter int FRAC_BITS = gn3_pkg::FracBitsDefault
) (
   input  logic                 clock,
   input  logic [7:0]           cell_x,
   input  logic [7:0]           cell_y,
   input  logic [7:0]           cell_z,
   input  logic [FRAC_BITS-1:0] frac_x,
   input  logic [FRAC_BITS-1:0] frac_y,
   input  logic [FRAC_BITS-1:0] frac_z,
   output logic signed [FRAC_BITS+2:0] corner [8]
);
   localparam int FB = FRAC_BITS;
   localparam int NB = FB + 3;

   logic [7:0] hz_ff [2];
   logic [7:0] hz_in [2];
   logic [7:0] hy_ff [4];
   logic [7:0] hy_in [4];
   logic [3:0] g_ff [8];
   logic [3:0] g_in [8];
   logic [7:0] cx1_ff, cy1_ff, cx2_ff;
   logic [FB-1:0] fx_ff [3];
   logic [FB-1:0] fy_ff [3];
   logic [FB-1:0] fz_ff [3];
   logic signed [NB-1:0] n_ff [8];
   logic signed [NB-1:0] n_in [8];

   // stage 1: z lookups
   always_comb begin
      for (int k = 0; k < 2; k++) hz_in[k] = gn3_pkg::HashRom[cell_z + 8'(k)];
   end

   // stage 2: y lookups
   always_comb begin
      for (int j = 0; j < 4; j++)
         hy_in[j] = gn3_pkg::HashRom[cy1_ff + 8'(j >> 1) + hz_ff[j & 1]];
   end

   // stage 3: x lookups and gradient pick
   always_comb begin
      for (int i = 0; i < 8; i++)
         g_in[i] = gn3_pkg::mod12(gn3_pkg::HashRom[cx2_ff + 8'(i >> 2) + hy_ff[i & 3]]);
   end

   // stage 4: dot products against corner offsets
   always_comb begin
      logic signed [NB-1:0] ox, oy, oz, tx, ty, tz;
      gn3_pkg::grad_type gr;
      for (int i = 0; i < 8; i++) begin
         gr = gn3_pkg::grad_of(g_ff[i]);
         ox = $signed({3'b0, fx_ff[2]}) - (((i >> 2) & 1) != 0 ? NB'(1) << FB : NB'(0));
         oy = $signed({3'b0, fy_ff[2]}) - (((i >> 1) & 1) != 0 ? NB'(1) << FB : NB'(0));
         oz = $signed({3'b0, fz_ff[2]}) - ((i & 1) != 0 ? NB'(1) << FB : NB'(0));
         tx = gr.gx == gn3_pkg::GPos ? ox : (gr.gx == gn3_pkg::GNeg ? -ox : '0);
         ty = gr.gy == gn3_pkg::GPos ? oy : (gr.gy == gn3_pkg::GNeg ? -oy : '0);
         tz = gr.gz == gn3_pkg::GPos ? oz : (gr.gz == gn3_pkg::GNeg ? -oz : '0);
         n_in[i] = tx + ty + tz;
      end
   end

   always_ff @(posedge clock) begin
      hz_ff <= hz_in;
      hy_ff <= hy_in;
      g_ff <= g_in;
      n_ff <= n_in;
      cy1_ff <= cell_y;
      cx1_ff <= cell_x;
      cx2_ff <= cx1_ff;
      fx_ff[0] <= frac_x; fx_ff[1] <= fx_ff[0]; fx_ff[2] <= fx_ff[1];
      fy_ff[0] <= frac_y; fy_ff[1] <= fy_ff[0]; fy_ff[2] <= fy_ff[1];
      fz_ff[0] <= frac_z; fz_ff[1] <= fz_ff[0]; fz_ff[2] <= fz_ff[1];
   end

   assign corner = n_ff;
endmodule

/* design/gn3_blend.sv */
// One linear blend a + floor(u*(b-a)/T), two register stages.
`timescale 1ns / 1ps
module gn3_blend #(
   parameter int FRAC_BITS = gn3_pkg::FracBitsDefault
) (
   input  logic                        clock,
   input  logic signed [FRAC_BITS+2:0] a,
   input  logic signed [FRAC_BITS+2:0] b,
   input  logic [FRAC_BITS:0]          u,
   output logic signed [FRAC_BITS+2:0] y
);
   localparam int FB = FRAC_BITS;
   localparam int NB = FB + 3;
   localparam int PB = NB + 1 + FB + 2;

   logic signed [NB:0] d_ff, d_in;
   logic signed [NB-1:0] a_ff;
   logic [FB:0] u_ff;
   logic signed [PB-1:0] pr;
   logic signed [NB-1:0] y_ff, y_in;

   // stage 1: difference
   assign d_in = (NB+1)'(b) - (NB+1)'(a);

   // stage 2: scale, arithmetic shift floors
   assign pr = PB'(d_ff) * $signed({1'b0, u_ff});
   assign y_in = a_ff + NB'(pr >>> FB);

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      a_ff <= a;
      u_ff <= u;
      y_ff <= y_in;
   end
   assign y = y_ff;
endmodule

/* design/gradient_noise_3d_top.sv */
// Top level of the 3-D gradient noise pipeline.
`timescale 1ns / 1ps
// Fully pipelined improved gradient noise: one point may be started every
// clock cycle and busy is never raised. Each result appears on rsp_noise_value
// with rsp_valid for one cycle; its path runs through the corner hashing and
// dot-product stages, matched by the fade stages plus one alignment register,
// then the x, y and z blend levels and one output register. Results come out
// in start order and cannot be held off by the receiver.
module gradient_noise_3d_top #(
   parameter int FRAC_BITS = gn3_pkg::FracBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [31:0]       req_coord_x,
   input  logic signed [31:0]       req_coord_y,
   input  logic signed [31:0]       req_coord_z,
   output logic                     rsp_valid,
   output logic signed [15:0]       rsp_noise_value
);
   localparam int FB = FRAC_BITS;
   localparam int NB = FB + 3;
   localparam int Lat = 11;

   logic [Lat-1:0] vld_ff, vld_in;
   logic signed [NB-1:0] corner [8];
   logic [FB:0] fu, fw, fz;
   logic [FB:0] fu_ff [1];
   logic [FB:0] fw_ff [3];
   logic [FB:0] fz_ff [5];
   logic signed [NB-1:0] nx [4];
   logic signed [NB-1:0] nxy [2];
   logic signed [NB-1:0] r;
   logic signed [15:0] out_ff, out_in;

   assign busy = 1'b0;

   // corners
   gn3_corner #(.FRAC_BITS(FB)) u_corner (
      .clock(clock),
      .cell_x(req_coord_x[FB+7:FB]), .cell_y(req_coord_y[FB+7:FB]),
      .cell_z(req_coord_z[FB+7:FB]),
      .frac_x(req_coord_x[FB-1:0]), .frac_y(req_coord_y[FB-1:0]),
      .frac_z(req_coord_z[FB-1:0]),
      .corner(corner)
   );

   gn3_fade #(.FRAC_BITS(FB)) u_fx (.clock(clock), .frac(req_coord_x[FB-1:0]), .fade(fu));
   gn3_fade #(.FRAC_BITS(FB)) u_fy (.clock(clock), .frac(req_coord_y[FB-1:0]), .fade(fw));
   gn3_fade #(.FRAC_BITS(FB)) u_fz (.clock(clock), .frac(req_coord_z[FB-1:0]), .fade(fz));

   // fade delay lines: each fade is held until its x, y or z blend level takes it
   always_ff @(posedge clock) begin
      fu_ff[0] <= fu;
      fw_ff[0] <= fw;
      for (int i = 1; i < 3; i++) fw_ff[i] <= fw_ff[i-1];
      fz_ff[0] <= fz;
      for (int i = 1; i < 5; i++) fz_ff[i] <= fz_ff[i-1];
   end

   // blend tree, x then y then z
   for (genvar i = 0; i < 4; i++) begin : g_bx
      gn3_blend #(.FRAC_BITS(FB)) u_b (.clock(clock), .a(corner[i]), .b(corner[4+i]),
                                       .u(fu_ff[0]), .y(nx[i]));
   end
   for (genvar i = 0; i < 2; i++) begin : g_by
      gn3_blend #(.FRAC_BITS(FB)) u_b (.clock(clock), .a(nx[i]), .b(nx[2+i]),
                                       .u(fw_ff[2]), .y(nxy[i]));
   end
   gn3_blend #(.FRAC_BITS(FB)) u_bz (.clock(clock), .a(nxy[0]), .b(nxy[1]),
                                     .u(fz_ff[4]), .y(r));

   // scale to Q2.14 and saturate
   always_comb begin
      logic signed [NB+14:0] v;
      if (FB >= 14) v = (NB+15)'(r >>> (FB >= 14 ? FB - 14 : 0));
      else v = (NB+15)'(r) <<< (FB >= 14 ? 0 : 14 - FB);
      if (v > 32767) out_in = 16'sd32767;
      else if (v < -32768) out_in = -16'sd32768;
      else out_in = v[15:0];
   end

   // valid shift line
   assign vld_in = {vld_ff[Lat-2:0], start & ~busy};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = vld_ff[Lat-1];
   assign rsp_noise_value = out_ff;

`ifndef SYNTHESIS
   a_lat: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> ##(Lat-1) rsp_valid) else $error("beat lost in pipeline");
   a_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, Lat)) else $error("result without start beat");
   a_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
`endif
endmodule
